// ===== src/ssm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared widths, register indexes and saturation limits for the stereo mixer.
// ----------------------------------------------------------------------------
package ssm_pkg;

	localparam int VOICE_W = 8;
	localparam int TONE_W  = 16;
	localparam int MIX_W   = 16;
	localparam int BYTE_W  = 8;
	localparam int CLIP_W  = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_TONE_ENABLE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOICE_ENABLE = 1'd1;

	localparam logic [MIX_W-1:0] SAT_MAX = 16'h7fff;
	localparam logic [MIX_W-1:0] SAT_MIN = 16'h8000;

	typedef struct packed {
		logic signed [VOICE_W-1:0] voice_left;
		logic signed [VOICE_W-1:0] voice_right;
		logic signed [TONE_W-1:0]  tone_left;
		logic signed [TONE_W-1:0]  tone_right;
	} frame_t;

endpackage : ssm_pkg
`default_nettype wire

// ===== src/saturating_stereo_sample_mixer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// saturating_stereo_sample_mixer
// Two-stage stereo mixer: voice << 8 plus tone, saturated, with mono output,
// peak trackers and a wrapping clip counter.
// ----------------------------------------------------------------------------
// Takes one frame per clock when the output side keeps up. A frame goes
// through an input register (muting applied) and a result register; the
// mix, saturation, peak compare and clip-counter add all sit between those
// two registers. The peak and clip outputs carry the tracker state after the
// frame they come with.
// Configuration writes take effect on the next frame entering the block.
module saturating_stereo_sample_mixer (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [ssm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [ssm_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire signed [ssm_pkg::VOICE_W-1:0]   voice_left,
	input  wire signed [ssm_pkg::VOICE_W-1:0]   voice_right,
	input  wire signed [ssm_pkg::TONE_W-1:0]    tone_left,
	input  wire signed [ssm_pkg::TONE_W-1:0]    tone_right,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic signed [ssm_pkg::MIX_W-1:0]    mix_left,
	output logic signed [ssm_pkg::MIX_W-1:0]    mix_right,
	output logic signed [ssm_pkg::MIX_W-1:0]    mix_mono,
	output logic signed [ssm_pkg::BYTE_W-1:0]   mix_mono_byte,
	output logic [ssm_pkg::VOICE_W-1:0]         voice_peak,
	output logic [ssm_pkg::TONE_W-1:0]          tone_peak,
	output logic [ssm_pkg::CLIP_W-1:0]          clip_total
);
	import ssm_pkg::*;

	logic tone_enable_q;
	logic voice_enable_q;

	logic   valid_s1;
	frame_t frame_s1;
	logic   adv_s1;
	logic   adv_s2;

	logic [VOICE_W-1:0] voice_peak_q;
	logic [TONE_W-1:0]  tone_peak_q;
	logic [CLIP_W-1:0]  clip_q;

	logic [VOICE_W-1:0] mag_vl, mag_vr, voice_peak_nx;
	logic [TONE_W-1:0]  mag_tl, tone_peak_nx;
	logic [MIX_W:0]     sum_l, sum_r, sum_mono;
	logic               clip_l, clip_r;
	logic [MIX_W-1:0]   sat_l, sat_r;
	logic [1:0]         clip_inc;
	logic [CLIP_W-1:0]  clip_nx;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_enable_q  <= 1'b1;
			voice_enable_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TONE_ENABLE:  tone_enable_q  <= cfg_data[0];
				REG_VOICE_ENABLE: voice_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake
	assign adv_s2   = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || adv_s2;
	assign adv_s1   = in_valid && in_ready;

	// input register, muting applied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			frame_s1.voice_left  <= voice_enable_q ? voice_left  : '0;
			frame_s1.voice_right <= voice_enable_q ? voice_right : '0;
			frame_s1.tone_left   <= tone_enable_q  ? tone_left   : '0;
			frame_s1.tone_right  <= tone_enable_q  ? tone_right  : '0;
		end
	end

	// mix and trackers
	always_comb begin
		mag_vl = frame_s1.voice_left[VOICE_W-1]  ? (~frame_s1.voice_left + 1'b1)
			: frame_s1.voice_left;
		mag_vr = frame_s1.voice_right[VOICE_W-1] ? (~frame_s1.voice_right + 1'b1)
			: frame_s1.voice_right;
		mag_tl = frame_s1.tone_left[TONE_W-1]    ? (~frame_s1.tone_left + 1'b1)
			: frame_s1.tone_left;

		voice_peak_nx = voice_peak_q;
		if (mag_vl > voice_peak_nx) begin
			voice_peak_nx = mag_vl;
		end
		if (mag_vr > voice_peak_nx) begin
			voice_peak_nx = mag_vr;
		end
		tone_peak_nx = (mag_tl > tone_peak_q) ? mag_tl : tone_peak_q;

		sum_l = {frame_s1.voice_left[VOICE_W-1], frame_s1.voice_left, 8'h00}
			+ {frame_s1.tone_left[TONE_W-1], frame_s1.tone_left};
		sum_r = {frame_s1.voice_right[VOICE_W-1], frame_s1.voice_right, 8'h00}
			+ {frame_s1.tone_right[TONE_W-1], frame_s1.tone_right};

		clip_l = sum_l[MIX_W] != sum_l[MIX_W-1];
		clip_r = sum_r[MIX_W] != sum_r[MIX_W-1];
		sat_l  = clip_l ? (sum_l[MIX_W] ? SAT_MIN : SAT_MAX) : sum_l[MIX_W-1:0];
		sat_r  = clip_r ? (sum_r[MIX_W] ? SAT_MIN : SAT_MAX) : sum_r[MIX_W-1:0];

		sum_mono = {sat_l[MIX_W-1], sat_l} + {sat_r[MIX_W-1], sat_r};

		clip_inc = {1'b0, clip_l} + {1'b0, clip_r};
		clip_nx  = clip_q + {{(CLIP_W-2){1'b0}}, clip_inc};
	end

	// result register and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			voice_peak_q <= '0;
			tone_peak_q  <= '0;
			clip_q       <= '0;
		end else begin
			if (!out_valid || out_ready) begin
				out_valid <= valid_s1;
			end
			if (adv_s2) begin
				voice_peak_q <= voice_peak_nx;
				tone_peak_q  <= tone_peak_nx;
				clip_q       <= clip_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			mix_left      <= sat_l;
			mix_right     <= sat_r;
			mix_mono      <= sum_mono[MIX_W:1];
			mix_mono_byte <= sum_mono[MIX_W:MIX_W-BYTE_W+1];
			voice_peak    <= voice_peak_nx;
			tone_peak     <= tone_peak_nx;
			clip_total    <= clip_nx;
		end
	end

endmodule : saturating_stereo_sample_mixer
`default_nettype wire

// ===== test/saturating_stereo_sample_mixer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturating_stereo_sample_mixer_tb
// Drives stereo frames through the mixer with random gaps on both sides of the
// handshake and compares every result against hand-picked values or against
// a cycle-free model of the mix, saturation, mono fold, peak trackers and clip
// counter. A short table of hand-picked frames (extremes, clipping on one or
// both sides, muting) runs first, then random frames under each mute setting.
// ----------------------------------------------------------------------------
module saturating_stereo_sample_mixer_tb;

	import ssm_pkg::*;

	localparam int HALF_PERIOD    = 2;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_FRAMES   = 70;

	typedef struct packed {
		logic [MIX_W-1:0]   mix_left;
		logic [MIX_W-1:0]   mix_right;
		logic [MIX_W-1:0]   mix_mono;
		logic [BYTE_W-1:0]  mix_mono_byte;
		logic [VOICE_W-1:0] voice_peak;
		logic [TONE_W-1:0]  tone_peak;
		logic [CLIP_W-1:0]  clip_total;
	} mix_result_t;

	typedef struct {
		bit          tone_en;
		bit          voice_en;
		frame_t      frame;
		bit          typed;
		mix_result_t want;
	} stim_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_index = '0;
	logic [CFG_DATA_W-1:0]        cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic signed [VOICE_W-1:0]    voice_left = '0;
	logic signed [VOICE_W-1:0]    voice_right = '0;
	logic signed [TONE_W-1:0]     tone_left = '0;
	logic signed [TONE_W-1:0]     tone_right = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic signed [MIX_W-1:0]      mix_left;
	logic signed [MIX_W-1:0]      mix_right;
	logic signed [MIX_W-1:0]      mix_mono;
	logic signed [BYTE_W-1:0]     mix_mono_byte;
	logic [VOICE_W-1:0]           voice_peak;
	logic [TONE_W-1:0]            tone_peak;
	logic [CLIP_W-1:0]            clip_total;

	// mirror of the block's registers and trackers
	bit                 tone_en_m = 1'b1;
	bit                 voice_en_m = 1'b1;
	logic [VOICE_W-1:0] voice_peak_m = '0;
	logic [TONE_W-1:0]  tone_peak_m = '0;
	logic [CLIP_W-1:0]  clip_m = '0;

	mix_result_t pending_mix_q[$];
	stim_row_t   stim_rows[$];
	int          err_cnt = 0;
	int          idle_cycles = 0;
	bit          full_rate = 1'b0;

	saturating_stereo_sample_mixer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.voice_left(voice_left),
		.voice_right(voice_right),
		.tone_left(tone_left),
		.tone_right(tone_right),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mix_left(mix_left),
		.mix_right(mix_right),
		.mix_mono(mix_mono),
		.mix_mono_byte(mix_mono_byte),
		.voice_peak(voice_peak),
		.tone_peak(tone_peak),
		.clip_total(clip_total)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (full_rate || r < 78)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int clamp_side(int x);
		if (x > 32767) begin
			clip_m = clip_m + 1;
			return 32767;
		end
		if (x < -32768) begin
			clip_m = clip_m + 1;
			return -32768;
		end
		return x;
	endfunction

	// mute, track peaks, mix with saturation, fold to mono
	function automatic mix_result_t mix_predict(frame_t f);
		int vl, vr, tl, tr, l, r, mono, mbyte;
		mix_result_t res;
		vl = voice_en_m ? int'(f.voice_left) : 0;
		vr = voice_en_m ? int'(f.voice_right) : 0;
		tl = tone_en_m ? int'(f.tone_left) : 0;
		tr = tone_en_m ? int'(f.tone_right) : 0;
		if ((vl < 0 ? -vl : vl) > int'(voice_peak_m))
			voice_peak_m = VOICE_W'(vl < 0 ? -vl : vl);
		if ((vr < 0 ? -vr : vr) > int'(voice_peak_m))
			voice_peak_m = VOICE_W'(vr < 0 ? -vr : vr);
		if ((tl < 0 ? -tl : tl) > int'(tone_peak_m))
			tone_peak_m = TONE_W'(tl < 0 ? -tl : tl);
		l = clamp_side(vl * 256 + tl);
		r = clamp_side(vr * 256 + tr);
		mono = (l + r) >>> 1;
		mbyte = mono >>> 8;
		res.mix_left = l[15:0];
		res.mix_right = r[15:0];
		res.mix_mono = mono[15:0];
		res.mix_mono_byte = mbyte[7:0];
		res.voice_peak = voice_peak_m;
		res.tone_peak = tone_peak_m;
		res.clip_total = clip_m;
		return res;
	endfunction

	function automatic logic [15:0] rand_sample(int w);
		logic [15:0] v;
		case ($urandom_range(0, 7))
			0: v = 16'h8000 >> (16 - w);
			1: v = 16'h7fff >> (16 - w);
			2: v = 16'($urandom_range(0, 4)) - 16'd2;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	function automatic frame_t rand_frame();
		frame_t f;
		logic [15:0] a, b, c, d;
		a = rand_sample(VOICE_W);
		b = rand_sample(VOICE_W);
		c = rand_sample(TONE_W);
		d = rand_sample(TONE_W);
		f.voice_left = a[7:0];
		f.voice_right = b[7:0];
		f.tone_left = c;
		f.tone_right = d;
		return f;
	endfunction

	function automatic stim_row_t mk_row(bit ten, bit ven, int vl, int vr, int tl, int tr,
			bit typed, int ml, int mr, int mm, int mb, int vp, int tp, int ct);
		stim_row_t row;
		row.tone_en = ten;
		row.voice_en = ven;
		row.frame.voice_left = vl[7:0];
		row.frame.voice_right = vr[7:0];
		row.frame.tone_left = tl[15:0];
		row.frame.tone_right = tr[15:0];
		row.typed = typed;
		row.want.mix_left = ml[15:0];
		row.want.mix_right = mr[15:0];
		row.want.mix_mono = mm[15:0];
		row.want.mix_mono_byte = mb[7:0];
		row.want.voice_peak = vp[7:0];
		row.want.tone_peak = tp[15:0];
		row.want.clip_total = ct;
		return row;
	endfunction

	task automatic set_config(bit ten, bit ven);
		in_valid <= 1'b0;
		while (pending_mix_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_TONE_ENABLE;
		cfg_data <= ten;
		@(posedge clk);
		cfg_index <= REG_VOICE_ENABLE;
		cfg_data <= ven;
		@(posedge clk);
		cfg_we <= 1'b0;
		tone_en_m = ten;
		voice_en_m = ven;
	endtask

	task automatic send_frame(frame_t f, bit typed, mix_result_t want);
		int gap;
		mix_result_t pred;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		voice_left <= f.voice_left;
		voice_right <= f.voice_right;
		tone_left <= f.tone_left;
		tone_right <= f.tone_right;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		pred = mix_predict(f);
		pending_mix_q.push_back(typed ? want : pred);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			err_cnt++;
		end
	endtask

	// result side
	initial begin
		int stall;
		mix_result_t want;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready) begin
				if (pending_mix_q.size() == 0) begin
					$error("result transaction with nothing expected");
					err_cnt++;
				end else begin
					want = pending_mix_q.pop_front();
					check_field("mix_left", 32'(want.mix_left),
						32'($unsigned(mix_left)));
					check_field("mix_right", 32'(want.mix_right),
						32'($unsigned(mix_right)));
					check_field("mix_mono", 32'(want.mix_mono),
						32'($unsigned(mix_mono)));
					check_field("mix_mono_byte", 32'(want.mix_mono_byte),
						32'($unsigned(mix_mono_byte)));
					check_field("voice_peak", 32'(want.voice_peak), 32'(voice_peak));
					check_field("tone_peak", 32'(want.tone_peak), 32'(tone_peak));
					check_field("clip_total", want.clip_total, clip_total);
				end
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		bit ten_list[6];
		bit ven_list[6];
		ten_list = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
		ven_list = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

		// muted frames first so the peak trackers still have room to move
		stim_rows.push_back(mk_row(1, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(0, 0, -128, -128, -32768, -32768,
			1, 0, 0, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(1, 0, -128, 127, 100, -100,
			1, 100, -100, 0, 0, 0, 100, 0));
		stim_rows.push_back(mk_row(0, 1, 0, 0, 32767, -32768,
			1, 0, 0, 0, 0, 0, 100, 0));
		stim_rows.push_back(mk_row(0, 1, 127, 127, -32768, -32768,
			1, 32512, 32512, 32512, 127, 127, 100, 0));
		stim_rows.push_back(mk_row(1, 0, 127, 127, 32767, 32767,
			1, 32767, 32767, 32767, 127, 127, 32767, 0));
		stim_rows.push_back(mk_row(0, 1, -77, 33, 1, 2, 0, 0, 0, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(1, 0, 5, -5, -3000, 7, 0, 0, 0, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(1, 1, 127, -128, 0, 0,
			1, 32512, -32768, -128, -1, 128, 32767, 0));
		// both sides clip high, then both clip low
		stim_rows.push_back(mk_row(1, 1, 127, 127, 32767, 32767,
			1, 32767, 32767, 32767, 127, 128, 32767, 2));
		stim_rows.push_back(mk_row(1, 1, -128, -128, -32768, -32768,
			1, -32768, -32768, -32768, -128, 128, 32768, 4));
		stim_rows.push_back(mk_row(1, 1, 0, 0, 32767, -32768,
			1, 32767, -32768, -1, -1, 128, 32768, 4));
		stim_rows.push_back(mk_row(1, 1, -1, 1, 255, -256,
			1, -1, 0, -1, -1, 128, 32768, 4));
		// left lands exactly on the limit, right one past it
		stim_rows.push_back(mk_row(1, 1, 127, -128, 255, -1,
			1, 32767, -32768, -1, -1, 128, 32768, 5));
		stim_rows.push_back(mk_row(1, 1, 64, -64, 1000, -1000, 0, 0, 0, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(1, 1, -100, 50, 12345, -23456,
			0, 0, 0, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(1, 1, 1, -1, -32768, 32767, 0, 0, 0, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(1, 1, -128, 127, -32768, 32767,
			0, 0, 0, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(0, 0, 85, -86, 21845, -21846,
			0, 0, 0, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(1, 1, 0, -1, -1, -32768, 0, 0, 0, 0, 0, 0, 0, 0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].tone_en != tone_en_m || stim_rows[i].voice_en != voice_en_m)
				set_config(stim_rows[i].tone_en, stim_rows[i].voice_en);
			send_frame(stim_rows[i].frame, stim_rows[i].typed, stim_rows[i].want);
		end

		for (int p = 0; p < 6; p++) begin
			set_config(ten_list[p], ven_list[p]);
			full_rate = (p == 5);
			repeat (PHASE_FRAMES) send_frame(rand_frame(), 1'b0, '0);
		end
		full_rate = 1'b0;
		in_valid <= 1'b0;

		while (pending_mix_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
